// File: design/aci_pkg.sv
// Shared types and constants for the alignment column identity scorer.
// No dependencies; every module of the block imports this package.
package aci_pkg;

  localparam int COLUMN_BITS = 20;
  localparam int CNT_W       = COLUMN_BITS;
  localparam int SCORE_W     = COLUMN_BITS + 1;
  localparam int FRAC_W      = 17;
  localparam int NUM_W       = SCORE_W + FRAC_W - 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]         GAP_CHAR  = 8'd45;
  localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {{COLUMN_BITS{1'b1}}, 1'b0};
  localparam logic [FRAC_W-1:0]  FRAC_ONE  = {1'b1, {(FRAC_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0] letter;
    logic       column_end;
    logic       window_end;
  } item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score_halves;
    logic [CNT_W-1:0]   column_count;
    logic [FRAC_W-1:0]  identity_fraction;
  } result_t;

  // Window totals handed from the front to the divider.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [CNT_W-1:0]   count;
  } window_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// File: design/aci_front.sv
// Front end: classifies letters per column and sums column scores per window.
// Depends on aci_pkg; pushes finished window totals into aci_queue.
module aci_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  aci_pkg::item_t  item,
  input  logic            q_full,
  output logic            full,
  output logic            q_push,
  output aci_pkg::window_t q_data
);
  import aci_pkg::*;

  logic [7:0]         first_letter, first_letter_next;
  logic               gap_seen, gap_seen_next;
  logic               mismatch_seen, mismatch_seen_next;
  logic [SCORE_W-1:0] score_sum, score_sum_next;
  logic [CNT_W-1:0]   columns_seen, columns_seen_next;

  logic               accept;
  logic               col_close;
  logic [1:0]         pts;
  logic [SCORE_W:0]   score_wide;
  logic [SCORE_W-1:0] score_closed;
  logic [CNT_W-1:0]   count_closed;
  logic               gap_upd, mismatch_upd;
  logic [7:0]         first_upd;

  assign full      = q_full;
  assign accept    = push && !q_full;
  assign col_close = item.column_end || item.window_end;

  always_comb begin
    gap_upd      = gap_seen;
    mismatch_upd = mismatch_seen;
    first_upd    = first_letter;
    if (!mismatch_seen) begin
      if (item.letter == GAP_CHAR) begin
        gap_upd = 1'b1;
      end else if (first_letter != 8'd0 && item.letter != first_letter) begin
        mismatch_upd = 1'b1;
      end else begin
        first_upd = item.letter;
      end
    end

    if (mismatch_upd) begin
      pts = 2'd0;
    end else if (gap_upd) begin
      pts = 2'd1;
    end else begin
      pts = 2'd2;
    end

    // Saturate both running totals.
    score_wide = {1'b0, score_sum} + {{(SCORE_W-1){1'b0}}, pts};
    if (score_wide > {1'b0, SCORE_MAX}) begin
      score_closed = SCORE_MAX;
    end else begin
      score_closed = score_wide[SCORE_W-1:0];
    end
    if (columns_seen == COUNT_MAX) begin
      count_closed = COUNT_MAX;
    end else begin
      count_closed = columns_seen + 1'b1;
    end

    first_letter_next  = first_letter;
    gap_seen_next      = gap_seen;
    mismatch_seen_next = mismatch_seen;
    score_sum_next     = score_sum;
    columns_seen_next  = columns_seen;
    if (accept) begin
      if (col_close) begin
        first_letter_next  = 8'd0;
        gap_seen_next      = 1'b0;
        mismatch_seen_next = 1'b0;
        if (item.window_end) begin
          score_sum_next    = '0;
          columns_seen_next = '0;
        end else begin
          score_sum_next    = score_closed;
          columns_seen_next = count_closed;
        end
      end else begin
        first_letter_next  = first_upd;
        gap_seen_next      = gap_upd;
        mismatch_seen_next = mismatch_upd;
      end
    end
  end

  assign q_push       = accept && item.window_end;
  assign q_data.score = score_closed;
  assign q_data.count = count_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_letter  <= 8'd0;
      gap_seen      <= 1'b0;
      mismatch_seen <= 1'b0;
      score_sum     <= '0;
      columns_seen  <= '0;
    end else begin
      first_letter  <= first_letter_next;
      gap_seen      <= gap_seen_next;
      mismatch_seen <= mismatch_seen_next;
      score_sum     <= score_sum_next;
      columns_seen  <= columns_seen_next;
    end
  end

endmodule

// File: design/aci_queue.sv
// Short queue of window totals between the front end and the divider.
// Depends on aci_pkg for the entry type and depth.
module aci_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  aci_pkg::window_t wdata,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output aci_pkg::window_t rdata
);
  import aci_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_QW-1:0] DEPTH_CNT = CNT_QW'(QUEUE_DEPTH);

  window_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_QW-1:0]  fill;
  logic               do_push, do_pop;

  assign full    = (fill == DEPTH_CNT);
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/aci_back.sv
// Back end: restoring divider for the identity fraction plus the result register.
// Depends on aci_pkg; takes window totals from aci_queue.
module aci_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  aci_pkg::window_t  q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output aci_pkg::result_t  result
);
  import aci_pkg::*;

  localparam int STEP_W = $clog2(FRAC_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(FRAC_W - 1);

  back_state_t        state, state_next;
  logic [SCORE_W-1:0] score;
  logic [CNT_W-1:0]   count;
  logic [SCORE_W-1:0] divisor;
  logic [SCORE_W-1:0] rem;
  logic [FRAC_W-1:0]  num_lo;
  logic [FRAC_W-1:0]  quot;
  logic [STEP_W-1:0]  step;
  logic               out_valid;
  result_t            out_reg;

  logic               load_out;
  logic [NUM_W-1:0]   numer;
  logic [SCORE_W:0]   trial;
  logic               take;

  // Rounded numerator: score * 2^16 + count.
  assign numer = {q_data.score, {(FRAC_W-1){1'b0}}} + NUM_W'(q_data.count);
  assign trial = {rem, num_lo[FRAC_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: if (!q_empty) state_next = BK_DIV;
      BK_DIV:  if (step == LAST_STEP) state_next = BK_DONE;
      BK_DONE: if (!out_valid || pop) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: q_pop    = !q_empty;
      BK_DONE: load_out = !out_valid || pop;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Divider datapath: one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      score   <= q_data.score;
      count   <= q_data.count;
      divisor <= {q_data.count, 1'b0};
      rem     <= {1'b0, numer[NUM_W-1:FRAC_W]};
      num_lo  <= numer[FRAC_W-1:0];
      step    <= '0;
    end else if (state == BK_DIV) begin
      if (take) begin
        rem <= trial[SCORE_W-1:0] - divisor;
      end else begin
        rem <= trial[SCORE_W-1:0];
      end
      quot   <= {quot[FRAC_W-2:0], take};
      num_lo <= {num_lo[FRAC_W-2:0], 1'b0};
      step   <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_reg.score_halves      <= score;
      out_reg.column_count      <= count;
      out_reg.identity_fraction <= quot;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

  a_frac_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_reg.identity_fraction <= FRAC_ONE))
    else $error("identity fraction above one");

  a_score_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, out_reg.score_halves} <= {1'b0, out_reg.column_count, 1'b0}))
    else $error("score exceeds twice the column count");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && $stable(out_reg)))
    else $error("unaccepted result changed");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == BK_DIV && step == '0))
    else $error("divider did not start after queue pop");

endmodule

// File: design/alignment_column_identity.sv
// Top level of the alignment column identity scorer.
// Depends on aci_pkg, aci_front, aci_queue and aci_back.
//
// Usage:
//   Input side is a queue write port: drive item (letter, column_end,
//   window_end) with push; the item is taken on a clock edge where push is
//   high and full is low. Letters of one column arrive one per cycle, the
//   last one flagged by column_end; window_end closes the column and the
//   window at once.
//   Result side is a queue read port: while empty is low, result holds the
//   oldest window (score in half units, column count, Q1.16 fraction);
//   pulse pop to take it.
// Data flow:
//   The front end takes one letter per cycle while full is low. Each window
//   end is passed through a two-entry queue to a restoring divider that
//   resolves one quotient bit per cycle. A window moves from the queue through
//   the divider's idle, divide and done states; a new window is taken only in idle.
//   full rises only when the window queue holds two unfinished windows.
// Reset (rst, synchronous) clears column state, totals, queue fill and the result valid flag.
// A stalled receiver holds the result register; the divider then waits
// with its answer, the queue fills, and finally full stops the input.
module alignment_column_identity (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  aci_pkg::item_t    item,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output aci_pkg::result_t  result
);
  import aci_pkg::*;

  logic    q_push, q_pop, q_full, q_empty;
  window_t q_wdata, q_rdata;

  aci_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .q_full (q_full),
    .full   (full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  aci_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  aci_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
